FILE: hw/rtl/lsia_pkg.sv
// shared types, constants and helper functions of the interval allocator
package lsia_pkg;

  localparam int unsigned NUM_REGS   = 14;
  localparam int unsigned INDEX_BITS = 16;
  localparam int unsigned REG_W      = 4;
  localparam int unsigned ERR_W      = 2;
  localparam int unsigned PTR_W      = $clog2(NUM_REGS);
  localparam int unsigned CNT_W      = $clog2(NUM_REGS + 1);
  localparam int unsigned SUM_W      = PTR_W + 1;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK      = 2'd0,
    ERR_NO_FREE = 2'd1,
    ERR_BUSY    = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RET_RD,
    ST_RET_CHK,
    ST_ALLOC,
    ST_INS_RD,
    ST_INS_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [INDEX_BITS-1:0] end_idx;
    logic [REG_W-1:0]      reg_idx;
  } entry_t;

  typedef struct packed {
    logic             re;
    logic [PTR_W-1:0] raddr;
    logic             we;
    logic [PTR_W-1:0] waddr;
    entry_t           wdata;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [REG_W-1:0] reg_idx;
    err_e             err;
  } result_t;

  typedef struct packed {
    logic                idle;
    logic [CNT_W-1:0]    count;
    logic [NUM_REGS-1:0] free_set;
  } status_t;

  // physical slot of a logical list position in the circular buffer
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(ptr) + SUM_W'(off);
    if (s >= SUM_W'(NUM_REGS)) begin
      s = s - SUM_W'(NUM_REGS);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [REG_W-1:0] lowest_free(input logic [NUM_REGS-1:0] set);
    logic [REG_W-1:0] idx;
    idx = '0;
    for (int i = NUM_REGS - 1; i >= 0; i--) begin
      if (set[i]) begin
        idx = REG_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: hw/rtl/lsia_active_ram.sv
// active list storage: one write port, one registered read port
module lsia_active_ram (
  input  logic                clk_i,
  input  lsia_pkg::mem_req_t  req_i,
  output lsia_pkg::entry_t    rdata_o
);

  lsia_pkg::entry_t mem_q [lsia_pkg::NUM_REGS];
  lsia_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lsia_ctrl.sv
// sequencer: retire expired entries, pick a register, sorted insert
module lsia_ctrl (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [lsia_pkg::INDEX_BITS-1:0]       range_start_i,
  input  logic [lsia_pkg::INDEX_BITS-1:0]       range_end_i,
  input  logic                                  is_preassigned_i,
  input  logic [lsia_pkg::REG_W-1:0]            preassigned_index_i,
  input  logic                                  first_of_batch_i,
  output lsia_pkg::mem_req_t                    mem_req_o,
  input  lsia_pkg::entry_t                      mem_rdata_i,
  output lsia_pkg::result_t                     res_o,
  input  logic                                  res_ready_i,
  output lsia_pkg::status_t                     status_o
);

  lsia_pkg::state_e                      state_q, state_d;
  logic [lsia_pkg::NUM_REGS-1:0]         free_q, free_d;
  logic [lsia_pkg::CNT_W-1:0]            count_q, count_d;
  logic [lsia_pkg::PTR_W-1:0]            head_q, head_d;
  logic [lsia_pkg::CNT_W-1:0]            k_q, k_d;
  logic [lsia_pkg::INDEX_BITS-1:0]       start_q, start_d;
  logic [lsia_pkg::INDEX_BITS-1:0]       end_q, end_d;
  logic                                  pre_q, pre_d;
  logic [lsia_pkg::REG_W-1:0]            pidx_q, pidx_d;
  logic [lsia_pkg::REG_W-1:0]            reg_q, reg_d;
  lsia_pkg::err_e                        err_q, err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsia_pkg::ST_IDLE;
      free_q  <= '1;
      count_q <= '0;
      head_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      count_q <= count_d;
      head_q  <= head_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
    pre_q   <= pre_d;
    pidx_q  <= pidx_d;
    reg_q   <= reg_d;
    err_q   <= err_d;
  end

  always_comb begin
    state_d    = state_q;
    free_d     = free_q;
    count_d    = count_q;
    head_d     = head_q;
    k_d        = k_q;
    start_d    = start_q;
    end_d      = end_q;
    pre_d      = pre_q;
    pidx_d     = pidx_q;
    reg_d      = reg_q;
    err_d      = err_q;
    in_ready_o = 1'b0;
    mem_req_o  = '0;
    res_o      = '0;

    case (state_q)
      lsia_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          start_d = range_start_i;
          end_d   = range_end_i;
          pre_d   = is_preassigned_i;
          pidx_d  = preassigned_index_i;
          if (first_of_batch_i) begin
            free_d  = '1;
            count_d = '0;
            head_d  = '0;
          end
          state_d = lsia_pkg::ST_RET_RD;
        end
      end

      lsia_pkg::ST_RET_RD: begin
        if (count_q == '0) begin
          state_d = lsia_pkg::ST_ALLOC;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = head_q;
          state_d         = lsia_pkg::ST_RET_CHK;
        end
      end

      lsia_pkg::ST_RET_CHK: begin
        if (mem_rdata_i.end_idx < start_q) begin
          free_d  = free_q | (lsia_pkg::NUM_REGS'(1) << mem_rdata_i.reg_idx);
          head_d  = lsia_pkg::wrap_add(head_q, lsia_pkg::CNT_W'(1));
          count_d = count_q - lsia_pkg::CNT_W'(1);
          state_d = lsia_pkg::ST_RET_RD;
        end else begin
          state_d = lsia_pkg::ST_ALLOC;
        end
      end

      lsia_pkg::ST_ALLOC: begin
        err_d = lsia_pkg::ERR_OK;
        reg_d = '0;
        if (!pre_q) begin
          if (free_q == '0) begin
            err_d = lsia_pkg::ERR_NO_FREE;
          end else begin
            reg_d = lsia_pkg::lowest_free(free_q);
          end
        end else begin
          if ((pidx_q >= lsia_pkg::REG_W'(lsia_pkg::NUM_REGS)) || !free_q[pidx_q]) begin
            err_d = lsia_pkg::ERR_BUSY;
          end else begin
            reg_d = pidx_q;
          end
        end
        if (err_d == lsia_pkg::ERR_OK) begin
          free_d  = free_q & ~(lsia_pkg::NUM_REGS'(1) << reg_d);
          k_d     = count_q;
          state_d = lsia_pkg::ST_INS_RD;
        end else begin
          state_d = lsia_pkg::ST_DONE;
        end
      end

      lsia_pkg::ST_INS_RD: begin
        if (k_q == '0) begin
          mem_req_o.we            = 1'b1;
          mem_req_o.waddr         = head_q;
          mem_req_o.wdata.end_idx = end_q;
          mem_req_o.wdata.reg_idx = reg_q;
          count_d                 = count_q + lsia_pkg::CNT_W'(1);
          state_d                 = lsia_pkg::ST_DONE;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = lsia_pkg::wrap_add(head_q, k_q - lsia_pkg::CNT_W'(1));
          state_d         = lsia_pkg::ST_INS_CHK;
        end
      end

      lsia_pkg::ST_INS_CHK: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = lsia_pkg::wrap_add(head_q, k_q);
        if (mem_rdata_i.end_idx > end_q) begin
          // shift the later-ending entry one slot toward the tail
          mem_req_o.wdata = mem_rdata_i;
          k_d             = k_q - lsia_pkg::CNT_W'(1);
          state_d         = lsia_pkg::ST_INS_RD;
        end else begin
          mem_req_o.wdata.end_idx = end_q;
          mem_req_o.wdata.reg_idx = reg_q;
          count_d                 = count_q + lsia_pkg::CNT_W'(1);
          state_d                 = lsia_pkg::ST_DONE;
        end
      end

      lsia_pkg::ST_DONE: begin
        res_o.valid   = 1'b1;
        res_o.reg_idx = reg_q;
        res_o.err     = err_q;
        if (res_ready_i) begin
          state_d = lsia_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lsia_pkg::ST_IDLE;
      end
    endcase
  end

  assign status_o.idle     = (state_q == lsia_pkg::ST_IDLE);
  assign status_o.count    = count_q;
  assign status_o.free_set = free_q;

endmodule

FILE: hw/rtl/linear_scan_interval_allocator_unit.sv
// linear-scan interval allocator: top level with output word register
// the active list walk sets the time from accept to result word: expired entries retire
// from the head, then later-ending entries shift toward the tail; the retire compare is
// skipped when retirement empties the list, the shift compare when the word lands at the
// head; each entry is read through the registered read port, then compared and written back
// one word in flight; the next is taken once the last result is registered, even while it waits
// reset: all registers free, active list empty, no result word pending
module linear_scan_interval_allocator_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [lsia_pkg::INDEX_BITS-1:0]       range_start_i,
  input  logic [lsia_pkg::INDEX_BITS-1:0]       range_end_i,
  input  logic                                  is_preassigned_i,
  input  logic [lsia_pkg::REG_W-1:0]            preassigned_index_i,
  input  logic                                  first_of_batch_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [lsia_pkg::REG_W-1:0]            register_index_o,
  output logic [lsia_pkg::ERR_W-1:0]            error_code_o
);

  lsia_pkg::mem_req_t mem_req;
  lsia_pkg::entry_t   mem_rdata;
  lsia_pkg::result_t  res;
  lsia_pkg::status_t  status;
  logic               res_ready;

  logic                          out_valid_q;
  logic [lsia_pkg::REG_W-1:0]    out_reg_q;
  logic [lsia_pkg::ERR_W-1:0]    out_err_q;

  lsia_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .range_start_i       (range_start_i),
    .range_end_i         (range_end_i),
    .is_preassigned_i    (is_preassigned_i),
    .preassigned_index_i (preassigned_index_i),
    .first_of_batch_i    (first_of_batch_i),
    .mem_req_o           (mem_req),
    .mem_rdata_i         (mem_rdata),
    .res_o               (res),
    .res_ready_i         (res_ready),
    .status_o            (status)
  );

  lsia_active_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_reg_q <= res.reg_idx;
      out_err_q <= res.err;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign register_index_o = out_reg_q;
  assign error_code_o     = out_err_q;

  // while idle, every register is either free or held by exactly one active entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.idle |-> ($countones(status.free_set) + int'(status.count) == lsia_pkg::NUM_REGS))
    else $error("free set and active count disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != lsia_pkg::ERR_OK) |-> (register_index_o == '0))
    else $error("error word carries a register index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (register_index_o < lsia_pkg::REG_W'(lsia_pkg::NUM_REGS)))
    else $error("register index out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while one is in flight");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the linear-scan interval allocator unit
module testbench;

  typedef struct packed {
    logic [lsia_pkg::REG_W-1:0] reg_idx;
    lsia_pkg::err_e             err;
  } grant_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [lsia_pkg::INDEX_BITS-1:0] range_start_i;
  logic [lsia_pkg::INDEX_BITS-1:0] range_end_i;
  logic                            is_preassigned_i;
  logic [lsia_pkg::REG_W-1:0]      preassigned_index_i;
  logic                            first_of_batch_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [lsia_pkg::REG_W-1:0]      register_index_o;
  logic [lsia_pkg::ERR_W-1:0]      error_code_o;

  logic [lsia_pkg::NUM_REGS-1:0]   model_free;
  int                              model_count;
  logic [lsia_pkg::INDEX_BITS-1:0] model_end [lsia_pkg::NUM_REGS];
  logic [lsia_pkg::REG_W-1:0]      model_reg [lsia_pkg::NUM_REGS];

  grant_t expected_grants[$];
  grant_t oldest_grant;
  int     gap_pct;
  int     stall_pct;
  int     mismatch_count;
  int     words_sent;
  int     granted_count;
  int     no_free_count;
  int     busy_count;

  linear_scan_interval_allocator_unit u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .range_start_i       (range_start_i),
    .range_end_i         (range_end_i),
    .is_preassigned_i    (is_preassigned_i),
    .preassigned_index_i (preassigned_index_i),
    .first_of_batch_i    (first_of_batch_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .register_index_o    (register_index_o),
    .error_code_o        (error_code_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("linear_scan_interval_allocator_unit: mismatch");
    $finish;
  end

  // allocation state of the unit, updated per accepted word
  function automatic void predict_grant(input logic [lsia_pkg::INDEX_BITS-1:0] s,
                                        input logic [lsia_pkg::INDEX_BITS-1:0] e,
                                        input logic pre,
                                        input logic [lsia_pkg::REG_W-1:0] idx,
                                        input logic first);
    grant_t g;
    int     slot;
    bit     found;
    g.reg_idx = '0;
    g.err     = lsia_pkg::ERR_OK;
    found     = 1'b0;
    if (first) begin
      model_count = 0;
      model_free  = '1;
    end
    while (model_count > 0 && model_end[0] < s) begin
      model_free[model_reg[0]] = 1'b1;
      for (int k = 1; k < model_count; k++) begin
        model_end[k-1] = model_end[k];
        model_reg[k-1] = model_reg[k];
      end
      model_count--;
    end
    if (!pre) begin
      for (int i = 0; i < lsia_pkg::NUM_REGS; i++) begin
        if (!found && model_free[i]) begin
          g.reg_idx = lsia_pkg::REG_W'(i);
          found     = 1'b1;
        end
      end
      if (!found) begin
        g.err = lsia_pkg::ERR_NO_FREE;
      end
    end else if (idx >= lsia_pkg::NUM_REGS || !model_free[idx]) begin
      g.err = lsia_pkg::ERR_BUSY;
    end else begin
      g.reg_idx = idx;
    end
    if (g.err == lsia_pkg::ERR_OK) begin
      model_free[g.reg_idx] = 1'b0;
      slot = model_count;
      for (int k = 0; k < model_count; k++) begin
        if (model_end[k] > e) begin
          slot = k;
          break;
        end
      end
      for (int k = model_count; k > slot; k--) begin
        model_end[k] = model_end[k-1];
        model_reg[k] = model_reg[k-1];
      end
      model_end[slot] = e;
      model_reg[slot] = g.reg_idx;
      model_count++;
    end
    expected_grants.push_back(g);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 30) begin
      $display("%0t ns: %s got %0d, want %0d", $time, what, got, want);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected result word, register_index", register_index_o, 0);
        end else begin
          oldest_grant = expected_grants.pop_front();
          if (register_index_o !== oldest_grant.reg_idx) begin
            report_mismatch("register_index", register_index_o, oldest_grant.reg_idx);
          end
          if (error_code_o !== oldest_grant.err) begin
            report_mismatch("error_code", error_code_o, oldest_grant.err);
          end
          case (oldest_grant.err)
            lsia_pkg::ERR_OK:      granted_count++;
            lsia_pkg::ERR_NO_FREE: no_free_count++;
            default:               busy_count++;
          endcase
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_grant(range_start_i, range_end_i, is_preassigned_i, preassigned_index_i,
                      first_of_batch_i);
      end
    end
  end

  // receiver back-pressure in random bursts
  always @(negedge clk_i) begin
    if (rst_ni && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ready_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
      out_ready_i = 1'b1;
    end
  end

  // called and returns at a falling edge
  task automatic send_word(input logic [lsia_pkg::INDEX_BITS-1:0] s,
                           input logic [lsia_pkg::INDEX_BITS-1:0] e,
                           input logic pre, input logic [lsia_pkg::REG_W-1:0] idx,
                           input logic first);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    range_start_i       = s;
    range_end_i         = e;
    is_preassigned_i    = pre;
    preassigned_index_i = idx;
    first_of_batch_i    = first;
    in_valid_i          = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic test_fill_and_exhaust;
    send_word(16'd0, 16'hffff, 1'b0, 4'd0, 1'b1);
    for (int k = 1; k < lsia_pkg::NUM_REGS; k++) begin
      send_word(16'd1, 16'(1000 - 50 * k), 1'b0, 4'(k), 1'b0);
    end
    send_word(16'd2, 16'd2000, 1'b0, 4'd0, 1'b0);
  endtask

  task automatic test_preassigned_conflicts;
    send_word(16'd2, 16'd10, 1'b1, 4'd5, 1'b0);
    send_word(16'd2, 16'd10, 1'b1, 4'd14, 1'b0);
    send_word(16'd2, 16'd10, 1'b1, 4'd15, 1'b0);
  endtask

  task automatic test_retirement;
    send_word(16'd700, 16'd800, 1'b0, 4'd0, 1'b0);
    send_word(16'd700, 16'd800, 1'b1, 4'd9, 1'b0);
    send_word(16'd951, 16'd960, 1'b1, 4'd1, 1'b0);
  endtask

  task automatic test_odd_ranges;
    send_word(16'hffff, 16'd0, 1'b1, 4'd13, 1'b1);
    send_word(16'hffff, 16'hffff, 1'b1, 4'd13, 1'b0);
    send_word(16'd0, 16'd5, 1'b0, 4'd8, 1'b0);
    send_word(16'd3, 16'd3, 1'b1, 4'd0, 1'b0);
  endtask

  // batches of intervals in start order; noisy mode mixes in broken sequences
  task automatic test_random_batches(input int n_words, input bit noisy);
    int    cur;
    int    span;
    int    max_step;
    int    batch_left;
    int    sel;
    logic [lsia_pkg::INDEX_BITS-1:0] s;
    logic [lsia_pkg::INDEX_BITS-1:0] e;
    logic  pre;
    logic  first;
    logic [lsia_pkg::REG_W-1:0] idx;
    batch_left = 0;
    cur        = 0;
    max_step   = 1;
    for (int n = 0; n < n_words; n++) begin
      first = 1'b0;
      if (batch_left == 0) begin
        first      = 1'b1;
        batch_left = $urandom_range(4, 40);
        max_step   = $urandom_range(0, 1) ? 1 : 8;
        cur        = ($urandom_range(0, 9) == 0) ? $urandom_range(64000, 65535)
                                                 : $urandom_range(0, 60000);
      end
      batch_left--;
      cur += ($urandom_range(0, 9) == 0) ? $urandom_range(9, 300) : $urandom_range(0, max_step);
      if (cur > 65535) begin
        cur = 65535;
      end
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
        span = $urandom_range(0, 30);
      end else if (sel < 18) begin
        span = $urandom_range(0, 400);
      end else begin
        span = $urandom_range(0, 65535);
      end
      s   = lsia_pkg::INDEX_BITS'(cur);
      e   = lsia_pkg::INDEX_BITS'(cur + span);
      pre = ($urandom_range(0, 3) == 0);
      idx = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(14, 15))
                                         : 4'($urandom_range(0, 13));
      if (noisy && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       s = lsia_pkg::INDEX_BITS'($urandom_range(0, 65535));
          1:       e = lsia_pkg::INDEX_BITS'($urandom_range(0, 65535));
          default: first = 1'b1;
        endcase
      end
      send_word(s, e, pre, idx, first);
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    range_start_i       = '0;
    range_end_i         = '0;
    is_preassigned_i    = 1'b0;
    preassigned_index_i = '0;
    first_of_batch_i    = 1'b0;
    out_ready_i         = 1'b1;
    model_free          = '1;
    model_count         = 0;
    gap_pct             = 0;
    stall_pct           = 0;
    mismatch_count      = 0;
    words_sent          = 0;
    granted_count       = 0;
    no_free_count       = 0;
    busy_count          = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_fill_and_exhaust();
    test_preassigned_conflicts();
    test_retirement();
    test_odd_ranges();

    gap_pct   = 30;
    stall_pct = 30;
    test_random_batches(400, 1'b0);
    gap_pct   = 15;
    stall_pct = 60;
    test_random_batches(250, 1'b1);
    gap_pct   = 0;
    stall_pct = 0;
    test_random_batches(250, 1'b0);
    gap_pct   = 50;
    stall_pct = 10;
    test_random_batches(150, 1'b1);
    gap_pct   = 0;
    stall_pct = 0;
    test_random_batches(250, 1'b0);
    in_valid_i = 1'b0;

    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);

    $display("ran %0d interval words with sender gaps and receiver stalls", words_sent);
    $display("results: %0d granted, %0d no free register, %0d busy register",
             granted_count, no_free_count, busy_count);
    if (mismatch_count == 0) begin
      $display("linear_scan_interval_allocator_unit: match");
    end else begin
      $display("linear_scan_interval_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/lsia_pkg.sv
hw/rtl/lsia_active_ram.sv
hw/rtl/lsia_ctrl.sv
hw/rtl/linear_scan_interval_allocator_unit.sv
test/testbench.sv
